// ===== hw/rtl/ialu_pkg.sv =====
// Shared types, operation codes and helper functions of the integer ALU.
package ialu_pkg;

    localparam int WORD_BITS     = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DIV_STEPS     = 128;

    // Operation codes
    localparam logic [4:0] MODE_ADD    = 5'd0;
    localparam logic [4:0] MODE_ADC    = 5'd1;
    localparam logic [4:0] MODE_SUB    = 5'd2;
    localparam logic [4:0] MODE_SBB    = 5'd3;
    localparam logic [4:0] MODE_MUL    = 5'd4;
    localparam logic [4:0] MODE_SMUL   = 5'd5;
    localparam logic [4:0] MODE_MULHI  = 5'd6;
    localparam logic [4:0] MODE_SMULHI = 5'd7;
    localparam logic [4:0] MODE_DIV    = 5'd8;
    localparam logic [4:0] MODE_REM    = 5'd9;
    localparam logic [4:0] MODE_SDIV   = 5'd10;
    localparam logic [4:0] MODE_SREM   = 5'd11;
    localparam logic [4:0] MODE_OR     = 5'd12;
    localparam logic [4:0] MODE_XOR    = 5'd13;
    localparam logic [4:0] MODE_AND    = 5'd14;
    localparam logic [4:0] MODE_SHL    = 5'd15;
    localparam logic [4:0] MODE_SHR    = 5'd16;
    localparam logic [4:0] MODE_SAR    = 5'd17;
    localparam logic [4:0] MODE_SHLD   = 5'd18;
    localparam logic [4:0] MODE_SHRD   = 5'd19;
    localparam logic [4:0] MODE_ROL    = 5'd20;
    localparam logic [4:0] MODE_ROR    = 5'd21;
    localparam logic [4:0] MODE_CTZ    = 5'd22;
    localparam logic [4:0] MODE_SEXT   = 5'd23;
    localparam logic [4:0] MODE_POPCNT = 5'd24;

    // Flag bit positions
    localparam int CF_BIT = 0;
    localparam int PF_BIT = 1;
    localparam int AF_BIT = 2;
    localparam int ZF_BIT = 3;
    localparam int SF_BIT = 4;
    localparam int OF_BIT = 5;

    localparam logic [5:0] F_CF = 6'h01;
    localparam logic [5:0] F_PF = 6'h02;
    localparam logic [5:0] F_AF = 6'h04;
    localparam logic [5:0] F_ZF = 6'h08;
    localparam logic [5:0] F_SF = 6'h10;
    localparam logic [5:0] F_OF = 6'h20;

    typedef enum logic [3:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_LOGIC,
        CLS_SHIFT,
        CLS_DSHIFT,
        CLS_ROT,
        CLS_MISC,
        CLS_NONE
    } cls_t;

    // Decoded transaction passed from front to back
    typedef struct packed {
        logic [4:0]  mode;
        cls_t        cls;
        logic [63:0] b_w;
        logic [63:0] c_w;
        logic [63:0] as;
        logic [63:0] bs;
        logic [63:0] cs;
        logic [6:0]  s_bits;
        logic [63:0] ms;
        logic [63:0] sign;
        logic [6:0]  cmod;
        logic [5:0]  want;
    } dec_t;

    // Result transaction
    typedef struct packed {
        logic [63:0] result_value;
        logic [5:0]  flags_value;
        logic [5:0]  flags_undefined;
        logic        raises_exception;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [63:0] mask_of(input logic [7:0] bits);
        return (bits >= 8'd64) ? {64{1'b1}} : ((64'd1 << bits) - 64'd1);
    endfunction

    function automatic logic bit_of(input logic [63:0] x, input logic [7:0] k);
        return (k < 8'd64) ? x[k[5:0]] : 1'b0;
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] x, input logic [6:0] s);
        logic [63:0] sb;
        sb = 64'd1 << (s - 7'd1);
        if (s >= 7'd64)
        begin
            return x;
        end
        return ((x & mask_of({1'b0, s})) ^ sb) - sb;
    endfunction

endpackage

// ===== hw/rtl/integer_alu_with_status_flags.sv =====
// Top level of the integer ALU with status flags: front, queues and back end.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+---------------------------------------------
//  input    | in        | push / full         | mode, operand_a/b/c, size_code, flags_wanted
//  result   | out       | pop / empty         | result_value, flags_value, flags_undefined,
//           |           |                     | raises_exception
//
// One transaction a cycle for all operations but divide and remainder, while the result
// queue has room; a result passes through the input queue, execute stage and flag stage,
// then into the result queue.
// Divide and remainder by a nonzero divisor go through an iterative divider of 128 steps,
// one quotient bit a cycle, and each holds later transactions behind it in order.
// Reset clears queues and stage valids at once; no clearing pass is needed.
// The front keeps accepting while the back end stalls, until the input queue fills.
module integer_alu_with_status_flags #(
    parameter int QUEUE_DEPTH = ialu_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  mode,
    input  logic [63:0] operand_a,
    input  logic [63:0] operand_b,
    input  logic [63:0] operand_c,
    input  logic [1:0]  size_code,
    input  logic [5:0]  flags_wanted,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result_value,
    output logic [5:0]  flags_value,
    output logic [5:0]  flags_undefined,
    output logic        raises_exception
);
    import ialu_pkg::*;

    qstat_t  dq_stat, rq_stat;
    logic    dq_wr, dq_rd, rq_wr;
    dec_t    dq_wdata, dq_rdata;
    res_t    rq_wdata, rq_rdata;

    ialu_front u_front (
        .push         (push),
        .full         (full),
        .mode         (mode),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .operand_c    (operand_c),
        .size_code    (size_code),
        .flags_wanted (flags_wanted),
        .q_stat       (dq_stat),
        .q_wr         (dq_wr),
        .q_data       (dq_wdata)
    );

    ialu_queue #(
        .ENTRY_T (dec_t),
        .DEPTH   (QUEUE_DEPTH)
    ) u_dec_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (dq_wr),
        .wr_data (dq_wdata),
        .rd_en   (dq_rd),
        .rd_data (dq_rdata),
        .stat    (dq_stat)
    );

    ialu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (dq_stat),
        .q_data (dq_rdata),
        .q_rd   (dq_rd),
        .r_stat (rq_stat),
        .r_wr   (rq_wr),
        .r_data (rq_wdata)
    );

    ialu_queue #(
        .ENTRY_T (res_t),
        .DEPTH   (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rq_wr),
        .wr_data (rq_wdata),
        .rd_en   (pop),
        .rd_data (rq_rdata),
        .stat    (rq_stat)
    );

    assign empty            = rq_stat.empty;
    assign result_value     = rq_rdata.result_value;
    assign flags_value      = rq_rdata.flags_value;
    assign flags_undefined  = rq_rdata.flags_undefined;
    assign raises_exception = rq_rdata.raises_exception;

endmodule

// ===== hw/rtl/ialu_queue.sv =====
// Small first-in first-out queue of transactions.
module ialu_queue #(
    parameter type ENTRY_T = logic,
    parameter int  DEPTH   = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  ENTRY_T            wr_data,
    input  logic              rd_en,
    output ENTRY_T            rd_data,
    output ialu_pkg::qstat_t  stat
);
    import ialu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ENTRY_T             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/ialu_front.sv =====
// Front end: accepts transactions, cuts operands to width and classifies them.
module ialu_front (
    input  logic                 push,
    output logic                 full,
    input  logic [4:0]           mode,
    input  logic [63:0]          operand_a,
    input  logic [63:0]          operand_b,
    input  logic [63:0]          operand_c,
    input  logic [1:0]           size_code,
    input  logic [5:0]           flags_wanted,
    input  ialu_pkg::qstat_t     q_stat,
    output logic                 q_wr,
    output ialu_pkg::dec_t       q_data
);
    import ialu_pkg::*;

    localparam logic [6:0] WORD_W = 7'(WORD_BITS);

    logic [6:0]  s_raw;
    logic [6:0]  s_bits;
    logic [63:0] ms;
    cls_t        cls;

    assign full = q_stat.full;
    assign q_wr = push && !q_stat.full;

    // Work out operand width
    always_comb
    begin
        s_raw  = 7'd8 << size_code;
        s_bits = (s_raw > WORD_W) ? WORD_W : s_raw;
        ms     = mask_of({1'b0, s_bits});
    end

    // Classify the operation
    always_comb
    begin
        case (mode)
            MODE_ADD, MODE_ADC:                            cls = CLS_ADD;
            MODE_SUB, MODE_SBB:                            cls = CLS_SUB;
            MODE_MUL, MODE_SMUL, MODE_MULHI, MODE_SMULHI:  cls = CLS_MUL;
            MODE_DIV, MODE_REM, MODE_SDIV, MODE_SREM:      cls = CLS_DIV;
            MODE_OR, MODE_XOR, MODE_AND:                   cls = CLS_LOGIC;
            MODE_SHL, MODE_SHR, MODE_SAR:                  cls = CLS_SHIFT;
            MODE_SHLD, MODE_SHRD:                          cls = CLS_DSHIFT;
            MODE_ROL, MODE_ROR:                            cls = CLS_ROT;
            MODE_CTZ, MODE_SEXT, MODE_POPCNT:              cls = CLS_MISC;
            default:                                       cls = CLS_NONE;
        endcase
    end

    // Build the decoded transaction
    always_comb
    begin
        q_data.mode   = mode;
        q_data.cls    = cls;
        q_data.b_w    = operand_b;
        q_data.c_w    = operand_c;
        q_data.as     = operand_a & ms;
        q_data.bs     = operand_b & ms;
        q_data.cs     = operand_c & ms;
        q_data.s_bits = s_bits;
        q_data.ms     = ms;
        q_data.sign   = 64'd1 << (s_bits - 7'd1);
        q_data.cmod   = (s_bits == WORD_W) ? WORD_W : 7'd32;
        q_data.want   = flags_wanted;
    end

endmodule

// ===== hw/rtl/ialu_div.sv =====
// Iterative restoring divider, 128-bit dividend by 64-bit divisor, one bit a cycle.
module ialu_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  ack,
    input  logic [127:0]          dividend,
    input  logic [63:0]           divisor,
    output ialu_pkg::div_stat_t   stat,
    output logic [127:0]          quot,
    output logic [63:0]           rem
);
    import ialu_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [127:0]       num_reg, num_next;
    logic [127:0]       quot_reg, quot_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        dvs_reg, dvs_next;
    logic [63:0]        shifted;
    logic               take;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;
    assign rem       = rem_reg;

    // One step of shift and subtract
    always_comb
    begin
        shifted    = {rem_reg[62:0], num_reg[127]};
        take       = rem_reg[63] || (shifted >= dvs_reg);
        busy_next  = busy_reg;
        done_next  = done_reg;
        count_next = count_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            count_next = '0;
            num_next   = dividend;
            quot_next  = '0;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            num_next   = {num_reg[126:0], 1'b0};
            quot_next  = {quot_reg[126:0], take};
            rem_next   = take ? (shifted - dvs_reg) : shifted;
            count_next = count_reg + CNT_W'(1);
            if (count_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (ack)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Hold the datapath
    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

endmodule

// ===== hw/rtl/ialu_back.sv =====
// Back end: executes decoded transactions in two stages, divides through the divider.
module ialu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ialu_pkg::qstat_t    q_stat,
    input  ialu_pkg::dec_t      q_data,
    output logic                q_rd,
    input  ialu_pkg::qstat_t    r_stat,
    output logic                r_wr,
    output ialu_pkg::res_t      r_data
);
    import ialu_pkg::*;

    typedef struct packed {
        logic        is_mul;
        logic        mul_signed;
        logic        mul_neg;
        logic        mul_low;
        logic [6:0]  s_bits;
        logic [63:0] ms;
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
        logic [63:0] res;
        logic [5:0]  val;
        logic [5:0]  done;
        logic [5:0]  compute;
        logic [5:0]  undef;
        logic        exc;
        logic        valid;
        logic [63:0] as;
        logic [63:0] fb;
        logic [63:0] sign;
    } st2_t;

    dec_t        s1_reg, s1_next;
    logic        s1_valid_reg, s1_valid_next;
    st2_t        s2_reg, s2_next;
    logic        s2_valid_reg, s2_valid_next;

    logic        s1_is_div, div_zero, s1_done, s1_fire, s1_ready, s2_ready;
    logic        div_start, div_ack;
    div_stat_t   div_stat;
    logic [127:0] div_quot;
    logic [63:0] div_rem;

    // Divider operand preparation
    logic [63:0] nl, nh, dv;
    logic        dn, vn, div_signed, div_isrem;
    logic [127:0] num_neg;
    logic [7:0]  two_s;

    function automatic logic [5:0] dflags(input logic [5:0] remain, input logic [63:0] res,
                                          input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] sign);
        logic [5:0] v;
        v = '0;
        if (remain[ZF_BIT] && res == 64'd0)                   v[ZF_BIT] = 1'b1;
        if (remain[PF_BIT] && !(^res[7:0]))                   v[PF_BIT] = 1'b1;
        if (remain[SF_BIT] && |(res & sign))                  v[SF_BIT] = 1'b1;
        if (remain[CF_BIT] && res < a)                        v[CF_BIT] = 1'b1;
        if (remain[AF_BIT] && res[3:0] < a[3:0])              v[AF_BIT] = 1'b1;
        if (remain[OF_BIT] && |(~(a ^ b) & (a ^ res) & sign)) v[OF_BIT] = 1'b1;
        return v;
    endfunction

    function automatic logic [6:0] ctz64(input logic [63:0] x);
        logic [7:0]      nz;
        logic [2:0]      tz [8];
        logic [6:0]      k;
        nz = '0;
        k  = 7'd64;
        for (int i = 0; i < 8; i++)
        begin
            nz[i] = |x[8*i +: 8];
            tz[i] = 3'd0;
            for (int j = 7; j >= 0; j--)
            begin
                if (x[8*i + j])
                begin
                    tz[i] = 3'(j);
                end
            end
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (nz[i])
            begin
                k = {1'b0, 3'(i), tz[i]};
            end
        end
        return k;
    endfunction

    function automatic logic [6:0] popcnt64(input logic [63:0] x);
        logic [3:0] lane [8];
        logic [6:0] k;
        k = '0;
        for (int i = 0; i < 8; i++)
        begin
            lane[i] = '0;
            for (int j = 0; j < 8; j++)
            begin
                lane[i] = lane[i] + {3'd0, x[8*i + j]};
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            k = k + {3'd0, lane[i]};
        end
        return k;
    endfunction

    // Stage handshakes
    assign s1_is_div = (s1_reg.cls == CLS_DIV);
    assign div_zero  = (s1_reg.cs == 64'd0);
    assign s2_ready  = !s2_valid_reg || !r_stat.full;
    assign s1_done   = s1_valid_reg && (!s1_is_div || div_zero || div_stat.done);
    assign s1_fire   = s1_done && s2_ready;
    assign s1_ready  = !s1_valid_reg || s1_fire;
    assign q_rd      = s1_ready && !q_stat.empty;
    assign div_start = s1_valid_reg && s1_is_div && !div_zero && !div_stat.busy
                       && !div_stat.done;
    assign div_ack   = s1_fire && s1_is_div;
    assign r_wr      = s2_valid_reg && !r_stat.full;

    // Prepare dividend and divisor
    always_comb
    begin
        div_signed = (s1_reg.mode == MODE_SDIV) || (s1_reg.mode == MODE_SREM);
        div_isrem  = (s1_reg.mode == MODE_REM) || (s1_reg.mode == MODE_SREM);
        two_s      = {s1_reg.s_bits, 1'b0};
        dn         = 1'b0;
        vn         = 1'b0;
        dv         = s1_reg.cs;
        if (s1_reg.s_bits >= 7'd64)
        begin
            nl = s1_reg.as;
            nh = s1_reg.bs;
        end
        else
        begin
            nl = s1_reg.as | (s1_reg.bs << s1_reg.s_bits);
            nh = s1_reg.bs >> (7'd64 - s1_reg.s_bits);
        end
        num_neg = '0;
        if (div_signed)
        begin
            dn = bit_of(s1_reg.bs, {1'b0, s1_reg.s_bits} - 8'd1);
            if (dn)
            begin
                if (two_s < 8'd64)
                begin
                    nl = nl | ~mask_of(two_s);
                    nh = {64{1'b1}};
                end
                else if (two_s < 8'd128)
                begin
                    nh = nh | ~mask_of(two_s - 8'd64);
                end
                num_neg = ~{nh, nl} + 128'd1;
                nh      = num_neg[127:64];
                nl      = num_neg[63:0];
            end
            vn = bit_of(s1_reg.cs, {1'b0, s1_reg.s_bits} - 8'd1);
            if (vn)
            begin
                dv = 64'd0 - sext(s1_reg.cs, s1_reg.s_bits);
            end
        end
    end

    ialu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ack      (div_ack),
        .dividend ({nh, nl}),
        .divisor  (dv),
        .stat     (div_stat),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Stage one: execute everything but the multiply sum
    always_comb
    begin
        logic [63:0] as, bs, res, fb, xs, ys, mx, my, ql, qh;
        logic [5:0]  compute, undef, done, val, u;
        logic [6:0]  S, n, r, m;
        logic [7:0]  s8, n8, m8;
        logic        cin, cf, of, ovf, qn;

        as      = s1_reg.as;
        bs      = s1_reg.bs;
        S       = s1_reg.s_bits;
        s8      = {1'b0, S};
        compute = s1_reg.want;
        undef   = '0;
        done    = '0;
        val     = '0;
        res     = '0;
        fb      = bs;
        xs      = '0;
        ys      = '0;
        mx      = as;
        my      = bs;
        n       = '0;
        r       = '0;
        m       = '0;
        n8      = '0;
        m8      = '0;
        u       = '0;
        cin     = 1'b0;
        cf      = 1'b0;
        of      = 1'b0;
        ovf     = 1'b0;
        qn      = 1'b0;
        ql      = div_quot[63:0];
        qh      = div_quot[127:64];

        s2_next            = '0;
        s2_next.exc        = 1'b0;
        s2_next.valid      = 1'b1;

        case (s1_reg.cls)
            CLS_ADD:
            begin
                cin = (s1_reg.mode == MODE_ADC);
                res = (as + bs + {63'd0, cin}) & s1_reg.ms;
                if (cin)
                begin
                    done = F_CF | F_AF;
                    if (compute[CF_BIT] && res <= as)             val[CF_BIT] = 1'b1;
                    if (compute[AF_BIT] && res[3:0] <= as[3:0])   val[AF_BIT] = 1'b1;
                end
            end
            CLS_SUB:
            begin
                cin  = (s1_reg.mode == MODE_SBB);
                res  = (as - bs - {63'd0, cin}) & s1_reg.ms;
                done = F_CF | F_AF | F_OF;
                if (compute[CF_BIT] && (cin ? res >= as : res > as))
                    val[CF_BIT] = 1'b1;
                if (compute[AF_BIT] && (cin ? res[3:0] >= as[3:0] : res[3:0] > as[3:0]))
                    val[AF_BIT] = 1'b1;
                if (compute[OF_BIT] && |((as ^ bs) & (as ^ res) & s1_reg.sign))
                    val[OF_BIT] = 1'b1;
            end
            CLS_MUL:
            begin
                s2_next.mul_signed = s1_reg.mode[0];
                if (s1_reg.mode[0])
                begin
                    xs = sext(as, S);
                    ys = sext(bs, S);
                    mx = xs[63] ? 64'd0 - xs : xs;
                    my = ys[63] ? 64'd0 - ys : ys;
                    s2_next.mul_neg = xs[63] ^ ys[63];
                end
                done = F_CF | F_OF;
            end
            CLS_DIV:
            begin
                if (div_zero)
                begin
                    s2_next.exc = 1'b1;
                end
                else if (div_isrem)
                begin
                    res = dn ? ((64'd0 - div_rem) & s1_reg.ms) : div_rem;
                end
                else
                begin
                    qn = dn ^ vn;
                    if (!div_signed)
                        ovf = (qh != 64'd0) || (S < 7'd64 && (ql >> S) != 64'd0);
                    else
                        ovf = (qh != 64'd0) || (qn ? ql > s1_reg.sign : ql >= s1_reg.sign);
                    if (ovf)
                        s2_next.exc = 1'b1;
                    else
                        res = qn ? ((64'd0 - ql) & s1_reg.ms) : ql;
                end
            end
            CLS_LOGIC:
            begin
                case (s1_reg.mode)
                    MODE_OR:  res = as | bs;
                    MODE_XOR: res = as ^ bs;
                    default:  res = as & bs;
                endcase
            end
            CLS_SHIFT:
            begin
                n  = s1_reg.b_w[6:0] & (s1_reg.cmod - 7'd1);
                n8 = {1'b0, n};
                case (s1_reg.mode)
                    MODE_SHL: res = (as << n) & s1_reg.ms;
                    MODE_SHR: res = as >> n;
                    default:  res = (as >> n) |
                                    (|(as & s1_reg.sign) ? (s1_reg.ms & ~(s1_reg.ms >> n)) : '0);
                endcase
                if (n == 7'd0)
                begin
                    compute = '0;
                end
                else
                begin
                    u = F_AF;
                    if (n > 7'd1) u = u | F_OF;
                    if (n > S)    u = u | F_CF;
                    undef   = u & compute;
                    compute = compute & ~u;
                    done    = F_CF | F_OF;
                    if (s1_reg.mode == MODE_SHL)
                    begin
                        cf = (n <= S) && bit_of(as, s8 - n8);
                        of = bit_of(as, s8 - 8'd1) != bit_of(as, s8 - 8'd2);
                    end
                    else
                    begin
                        cf = bit_of(as, n8 - 8'd1);
                        if (s1_reg.mode == MODE_SHR)
                            of = bit_of(as, s8 - 8'd1);
                        else
                            done = F_CF;
                    end
                    if (compute[CF_BIT] && cf)                  val[CF_BIT] = 1'b1;
                    if (compute[OF_BIT] && done[OF_BIT] && of)  val[OF_BIT] = 1'b1;
                end
            end
            CLS_DSHIFT:
            begin
                n  = s1_reg.c_w[6:0] & (s1_reg.cmod - 7'd1);
                n8 = {1'b0, n};
                if (n == 7'd0)
                begin
                    res     = as;
                    compute = '0;
                end
                else
                begin
                    m8 = s8 + {1'b0, s1_reg.cmod} - n8;
                    m  = m8[6:0] & (s1_reg.cmod - 7'd1);
                    if (s1_reg.mode == MODE_SHLD)
                        res = ((as << n) | (bs >> m)) & s1_reg.ms;
                    else
                        res = ((as >> n) | (bs << m)) & s1_reg.ms;
                    if (n > S)
                    begin
                        undef   = compute;
                        compute = '0;
                    end
                    else
                    begin
                        undef   = F_AF;
                        compute = compute & ~F_AF;
                        done    = F_CF | F_OF;
                        if (n > 7'd1)
                        begin
                            undef   = undef | F_OF;
                            compute = compute & ~F_OF;
                            done    = done & ~F_OF;
                        end
                        if (compute[OF_BIT] && |((res ^ as) & s1_reg.sign))
                            val[OF_BIT] = 1'b1;
                        if (compute[CF_BIT] && (s1_reg.mode == MODE_SHRD ?
                                                bit_of(as, n8 - 8'd1) : bit_of(as, s8 - n8)))
                            val[CF_BIT] = 1'b1;
                    end
                end
            end
            CLS_ROT:
            begin
                n = s1_reg.b_w[6:0] & (s1_reg.cmod - 7'd1);
                r = n & (S - 7'd1);
                if (s1_reg.mode == MODE_ROL)
                    r = (S - r) & (S - 7'd1);
                res = (r == 7'd0) ? as : (((as >> r) | (as << (S - r))) & s1_reg.ms);
                if (n == 7'd0)
                begin
                    compute = '0;
                end
                else
                begin
                    done = F_CF | F_OF;
                    if (n > 7'd1)
                    begin
                        undef   = F_OF;
                        compute = compute & ~F_OF;
                        done    = done & ~F_OF;
                    end
                    if (s1_reg.mode == MODE_ROR)
                    begin
                        if (compute[CF_BIT] && bit_of(res, s8 - 8'd1))  val[CF_BIT] = 1'b1;
                        if (compute[OF_BIT] && (bit_of(res, s8 - 8'd2) ^ bit_of(res, s8 - 8'd1)))
                            val[OF_BIT] = 1'b1;
                    end
                    else
                    begin
                        if (compute[CF_BIT] && res[0])  val[CF_BIT] = 1'b1;
                        if (compute[OF_BIT] && (res[0] ^ bit_of(res, s8 - 8'd1)))
                            val[OF_BIT] = 1'b1;
                    end
                end
            end
            CLS_MISC:
            begin
                fb = '0;
                case (s1_reg.mode)
                    MODE_CTZ:
                    begin
                        res  = {57'd0, (as == 64'd0) ? S : ctz64(as)};
                        done = F_CF;
                        if (compute[CF_BIT] && as == 64'd0)  val[CF_BIT] = 1'b1;
                    end
                    MODE_SEXT: res = sext(as, S);
                    default:   res = {57'd0, popcnt64(as)};
                endcase
            end
            default:
            begin
                s2_next.valid = 1'b0;
            end
        endcase

        s2_next.is_mul  = (s1_reg.cls == CLS_MUL);
        s2_next.mul_low = (s1_reg.mode < MODE_MULHI);
        s2_next.s_bits  = S;
        s2_next.ms      = s1_reg.ms;
        s2_next.p00     = {32'd0, mx[31:0]}  * {32'd0, my[31:0]};
        s2_next.p01     = {32'd0, mx[31:0]}  * {32'd0, my[63:32]};
        s2_next.p10     = {32'd0, mx[63:32]} * {32'd0, my[31:0]};
        s2_next.p11     = {32'd0, mx[63:32]} * {32'd0, my[63:32]};
        s2_next.res     = res;
        s2_next.val     = val;
        s2_next.done    = done;
        s2_next.compute = compute;
        s2_next.undef   = undef;
        s2_next.as      = as;
        s2_next.fb      = fb;
        s2_next.sign    = s1_reg.sign;
    end

    // Stage two: sum the product, then the common flags
    always_comb
    begin
        logic [127:0] prod;
        logic [63:0]  pl, ph, ext, hp, mres, res_f;
        logic [5:0]   val_f;
        logic [7:0]   s8;
        logic         ovf;

        s8   = {1'b0, s2_reg.s_bits};
        prod = {s2_reg.p11, s2_reg.p00}
             + {32'd0, s2_reg.p01, 32'd0}
             + {32'd0, s2_reg.p10, 32'd0};
        if (s2_reg.mul_neg)
            prod = ~prod + 128'd1;
        pl  = prod[63:0];
        ph  = prod[127:64];
        ext = bit_of(pl, s8 - 8'd1) ? {64{1'b1}} : 64'd0;
        hp  = (s2_reg.s_bits >= 7'd64) ? ph :
              (((pl >> s2_reg.s_bits) | (ph << (7'd64 - s2_reg.s_bits))) & s2_reg.ms);
        if (s2_reg.mul_signed)
            ovf = (ph != ext) || ((pl >> (s2_reg.s_bits - 7'd1)) !=
                                  (ext >> (s2_reg.s_bits - 7'd1)));
        else
            ovf = (hp != 64'd0);
        mres  = s2_reg.mul_low ? (pl & mask_of({s2_reg.s_bits, 1'b0})) : hp;
        res_f = s2_reg.is_mul ? mres : s2_reg.res;
        val_f = s2_reg.val;
        if (s2_reg.is_mul && ovf)
            val_f = val_f | (s2_reg.compute & (F_CF | F_OF));

        if (s2_reg.exc || !s2_reg.valid)
        begin
            r_data.result_value    = '0;
            r_data.flags_value     = '0;
            r_data.flags_undefined = '0;
        end
        else
        begin
            r_data.result_value    = res_f;
            r_data.flags_value     = val_f | dflags(s2_reg.compute & ~s2_reg.done, res_f,
                                                    s2_reg.as, s2_reg.fb, s2_reg.sign);
            r_data.flags_undefined = s2_reg.undef;
        end
        r_data.raises_exception = s2_reg.exc;
    end

    // Advance stage valids
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        s1_next       = s1_reg;
        if (s1_ready)
        begin
            s1_valid_next = !q_stat.empty;
            s1_next       = q_data;
        end
        if (s2_ready)
        begin
            s2_valid_next = s1_fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (s1_fire)
        begin
            s2_reg <= s2_next;
        end
    end

endmodule
